// ===== rtl/pid_controller_anti_windup_macros.svh =====
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion shorthands clocked on i_clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTI_WINDUP_MACROS_SVH
`define PID_CONTROLLER_ANTI_WINDUP_MACROS_SVH

// check while out of reset
`define PIDAW_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every edge, reset included
`define PIDAW_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, register indexes, limit status codes and APB sizing helpers.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int INTEG_W         = 48;
    localparam int TERM_W          = 62;
    localparam int TERM_LIMIT_LOG2 = 60;
    localparam int SUM_W           = 64;
    localparam int REG_INDEX_W     = 3;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_KP          = 3'd0,
        REG_KI          = 3'd1,
        REG_KD          = 3'd2,
        REG_OUT_LOW     = 3'd3,
        REG_OUT_HIGH    = 3'd4,
        REG_ANTI_WINDUP = 3'd5,
        REG_AUTO_MODE   = 3'd6
    } t_reg_index;

    typedef enum logic [1:0] {
        LIMIT_NONE = 2'd0,
        LIMIT_HIGH = 2'd1,
        LIMIT_LOW  = 2'd2
    } t_limit_status;

    function automatic int apb_data_w(input int dw);
        return (dw > 32) ? 64 : 32;
    endfunction

    function automatic int apb_lsb(input int dw);
        return (dw > 32) ? 3 : 2;
    endfunction

endpackage

// ===== rtl/pidaw_mul_term.sv =====
// ----------------------------------------------------------------------------
// PID term multiplier
// Signed gain times error, floor shift by the fraction bits, saturation to
// plus or minus 2^60, registered.
// ----------------------------------------------------------------------------
module pidaw_mul_term #(
    parameter int A_W       = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int B_W       = pidaw_pkg::DATA_WIDTH_DEF + 1,
    parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [A_W-1:0]               i_a,
    input  logic signed [B_W-1:0]               i_b,
    output logic signed [pidaw_pkg::TERM_W-1:0] o_term
);

    localparam int P_W = A_W + B_W;
    localparam int EW  = (P_W > pidaw_pkg::TERM_W) ? P_W : pidaw_pkg::TERM_W;
    localparam logic signed [EW-1:0] TERM_MAX = EW'(1) <<< pidaw_pkg::TERM_LIMIT_LOG2;
    localparam logic signed [EW-1:0] TERM_MIN = -TERM_MAX;

    logic signed [P_W-1:0]               prod;
    logic signed [P_W-1:0]               shifted;
    logic signed [EW-1:0]                wide;
    logic signed [pidaw_pkg::TERM_W-1:0] n_term;
    logic signed [pidaw_pkg::TERM_W-1:0] r_term;

    assign prod    = P_W'(i_a) * P_W'(i_b);
    assign shifted = prod >>> FRAC_BITS;
    assign wide    = EW'(shifted);

    always_comb begin
        if (wide > TERM_MAX) begin
            n_term = TERM_MAX[pidaw_pkg::TERM_W-1:0];
        end else if (wide < TERM_MIN) begin
            n_term = TERM_MIN[pidaw_pkg::TERM_W-1:0];
        end else begin
            n_term = wide[pidaw_pkg::TERM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

// ===== rtl/pid_controller_anti_windup.sv =====
// ----------------------------------------------------------------------------
// Positional PID controller with clamping anti-windup
// Fixed-point PID with output clamp, saturating integral and APB registers.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the output side is ready, and passes
// each item through its registers in turn: an input register forms the
// error and its difference from the previous error, a product register holds
// the three gain terms, and a result register closes the integral loop (sum,
// saturate, clamp and store decision). Results wait in the result register
// while earlier stages keep taking items until they fill. Configure only
// while no item is in flight. The control output always equals the held
// output, so manual mode repeats it unless a clear item zeroes it.
module pid_controller_anti_windup #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidaw_pkg::apb_lsb(DATA_WIDTH)+pidaw_pkg::REG_INDEX_W-1:0] paddr,
    input  logic [pidaw_pkg::apb_data_w(DATA_WIDTH)-1:0] pwdata,
    output logic [pidaw_pkg::apb_data_w(DATA_WIDTH)-1:0] prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_mode,
    input  logic signed [DATA_WIDTH-1:0] i_target_value,
    input  logic signed [DATA_WIDTH-1:0] i_measured_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_control_output,
    output logic [1:0]                   o_limit_status
);

    localparam int APB_W   = pidaw_pkg::apb_data_w(DATA_WIDTH);
    localparam int REG_LSB = pidaw_pkg::apb_lsb(DATA_WIDTH);
    localparam int ADDR_W  = REG_LSB + pidaw_pkg::REG_INDEX_W;
    localparam int ERR_W   = DATA_WIDTH + 1;
    localparam int DERR_W  = DATA_WIDTH + 2;
    localparam int TERM_W  = pidaw_pkg::TERM_W;
    localparam int SUM_W   = pidaw_pkg::SUM_W;
    localparam int INTEG_W = pidaw_pkg::INTEG_W;

    localparam logic signed [SUM_W-1:0] INT_MAX = (SUM_W'(1) <<< (INTEG_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] INT_MIN = -INT_MAX - SUM_W'(1);
    localparam logic signed [DATA_WIDTH-1:0] KP_RESET = DATA_WIDTH'(1) <<< FRAC_BITS;
    localparam logic signed [DATA_WIDTH-1:0] OUT_LOW_RESET = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] OUT_HIGH_RESET = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // configuration registers
    logic signed [DATA_WIDTH-1:0] r_kp;
    logic signed [DATA_WIDTH-1:0] r_ki;
    logic signed [DATA_WIDTH-1:0] r_kd;
    logic signed [DATA_WIDTH-1:0] r_out_low;
    logic signed [DATA_WIDTH-1:0] r_out_high;
    logic                         r_anti_windup;
    logic                         r_auto_mode;

    pidaw_pkg::t_reg_index reg_index;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign reg_index = pidaw_pkg::t_reg_index'(paddr[ADDR_W-1:REG_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp          <= KP_RESET;
            r_ki          <= '0;
            r_kd          <= '0;
            r_out_low     <= OUT_LOW_RESET;
            r_out_high    <= OUT_HIGH_RESET;
            r_anti_windup <= 1'b1;
            r_auto_mode   <= 1'b1;
        end else if (cfg_write) begin
            unique case (reg_index)
                pidaw_pkg::REG_KP:          r_kp          <= pwdata[DATA_WIDTH-1:0];
                pidaw_pkg::REG_KI:          r_ki          <= pwdata[DATA_WIDTH-1:0];
                pidaw_pkg::REG_KD:          r_kd          <= pwdata[DATA_WIDTH-1:0];
                pidaw_pkg::REG_OUT_LOW:     r_out_low     <= pwdata[DATA_WIDTH-1:0];
                pidaw_pkg::REG_OUT_HIGH:    r_out_high    <= pwdata[DATA_WIDTH-1:0];
                pidaw_pkg::REG_ANTI_WINDUP: r_anti_windup <= pwdata[0];
                pidaw_pkg::REG_AUTO_MODE:   r_auto_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            pidaw_pkg::REG_KP:          prdata = APB_W'($unsigned(r_kp));
            pidaw_pkg::REG_KI:          prdata = APB_W'($unsigned(r_ki));
            pidaw_pkg::REG_KD:          prdata = APB_W'($unsigned(r_kd));
            pidaw_pkg::REG_OUT_LOW:     prdata = APB_W'($unsigned(r_out_low));
            pidaw_pkg::REG_OUT_HIGH:    prdata = APB_W'($unsigned(r_out_high));
            pidaw_pkg::REG_ANTI_WINDUP: prdata = APB_W'(r_anti_windup);
            pidaw_pkg::REG_AUTO_MODE:   prdata = APB_W'(r_auto_mode);
            default:                    prdata = '0;
        endcase
    end

    // pipeline flow control
    logic r_a_valid;
    logic r_b_valid;
    logic r_c_valid;
    logic ready_a;
    logic ready_b;
    logic ready_c;
    logic in_accept;
    logic load_b;
    logic load_c;

    assign ready_c   = !r_c_valid || i_out_ready;
    assign ready_b   = !r_b_valid || ready_c;
    assign ready_a   = !r_a_valid || ready_b;
    assign in_accept = i_in_valid && ready_a;
    assign load_b    = r_a_valid && ready_b;
    assign load_c    = r_b_valid && ready_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_in_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (ready_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // stage A: error and error difference
    logic signed [ERR_W-1:0]  err;
    logic signed [DERR_W-1:0] derr;
    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [ERR_W-1:0]  n_prev_err;
    logic                     r_a_mode;
    logic signed [ERR_W-1:0]  r_a_err;
    logic signed [DERR_W-1:0] r_a_derr;

    assign err  = ERR_W'(i_target_value) - ERR_W'(i_measured_value);
    assign derr = DERR_W'(err) - DERR_W'(r_prev_err);

    always_comb begin
        n_prev_err = r_prev_err;
        if (i_mode == pidaw_pkg::MODE_CLEAR) begin
            n_prev_err = '0;
        end else if (r_auto_mode) begin
            n_prev_err = err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
        end else if (in_accept) begin
            r_prev_err <= n_prev_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_mode <= i_mode;
            r_a_err  <= err;
            r_a_derr <= derr;
        end
    end

    // stage B: gain products
    logic signed [TERM_W-1:0] p_term;
    logic signed [TERM_W-1:0] i_term;
    logic signed [TERM_W-1:0] d_term;
    logic                     r_b_mode;
    logic                     r_b_err_neg;
    logic                     r_b_err_zero;

    pidaw_mul_term #(
        .A_W       (DATA_WIDTH),
        .B_W       (ERR_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_p (
        .i_clk  (i_clk),
        .i_en   (load_b),
        .i_a    (r_kp),
        .i_b    (r_a_err),
        .o_term (p_term)
    );

    pidaw_mul_term #(
        .A_W       (DATA_WIDTH),
        .B_W       (ERR_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_i (
        .i_clk  (i_clk),
        .i_en   (load_b),
        .i_a    (r_ki),
        .i_b    (r_a_err),
        .o_term (i_term)
    );

    pidaw_mul_term #(
        .A_W       (DATA_WIDTH),
        .B_W       (DERR_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_d (
        .i_clk  (i_clk),
        .i_en   (load_b),
        .i_a    (r_kd),
        .i_b    (r_a_derr),
        .o_term (d_term)
    );

    always_ff @(posedge i_clk) begin
        if (load_b) begin
            r_b_mode     <= r_a_mode;
            r_b_err_neg  <= r_a_err[ERR_W-1];
            r_b_err_zero <= (r_a_err == '0);
        end
    end

    // stage C: integral, sum, clamp and result
    logic signed [INTEG_W-1:0]    r_integral;
    logic signed [INTEG_W-1:0]    n_integral;
    logic signed [DATA_WIDTH-1:0] r_held;
    logic signed [DATA_WIDTH-1:0] n_held;
    pidaw_pkg::t_limit_status     r_status;
    pidaw_pkg::t_limit_status     n_status;
    logic signed [SUM_W-1:0]      isum;
    logic signed [INTEG_W-1:0]    ni;
    logic signed [SUM_W-1:0]      usum;
    logic signed [SUM_W-1:0]      high_ext;
    logic signed [SUM_W-1:0]      low_ext;
    logic                         store;

    assign isum     = SUM_W'(r_integral) + SUM_W'(i_term);
    assign usum     = SUM_W'(p_term) + SUM_W'(ni) + SUM_W'(d_term);
    assign high_ext = SUM_W'(r_out_high);
    assign low_ext  = SUM_W'(r_out_low);

    always_comb begin
        if (isum > INT_MAX) begin
            ni = INT_MAX[INTEG_W-1:0];
        end else if (isum < INT_MIN) begin
            ni = INT_MIN[INTEG_W-1:0];
        end else begin
            ni = isum[INTEG_W-1:0];
        end
    end

    always_comb begin
        n_held     = r_held;
        n_integral = r_integral;
        n_status   = pidaw_pkg::LIMIT_NONE;
        store      = 1'b0;
        if (r_b_mode == pidaw_pkg::MODE_CLEAR) begin
            n_held     = '0;
            n_integral = '0;
        end else if (r_auto_mode) begin
            if (usum > high_ext) begin
                n_held   = r_out_high;
                n_status = pidaw_pkg::LIMIT_HIGH;
                store    = !r_anti_windup || r_b_err_neg || r_b_err_zero;
            end else if (usum < low_ext) begin
                n_held   = r_out_low;
                n_status = pidaw_pkg::LIMIT_LOW;
                store    = !r_anti_windup || !r_b_err_neg;
            end else begin
                n_held = usum[DATA_WIDTH-1:0];
                store  = 1'b1;
            end
            if (store) begin
                n_integral = ni;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_integral <= '0;
            r_status   <= pidaw_pkg::LIMIT_NONE;
        end else if (load_c) begin
            r_held     <= n_held;
            r_integral <= n_integral;
            r_status   <= n_status;
        end
    end

    assign o_in_ready       = ready_a;
    assign o_out_valid      = r_c_valid;
    assign o_control_output = r_held;
    assign o_limit_status   = r_status;

endmodule

// ===== rtl/pidaw_assert.sv =====
// ----------------------------------------------------------------------------
// PID controller port checks
// Port-level assertions on the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "pid_controller_anti_windup_macros.svh"

module pidaw_assert #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [DATA_WIDTH-1:0] o_control_output,
    input logic [1:0]                   o_limit_status
);

    localparam logic [1:0] MAX_STATUS = pidaw_pkg::LIMIT_LOW;

    property p_result_holds;
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_control_output) && $stable(o_limit_status));
    endproperty

    `PIDAW_ASSERT(a_status_code, o_out_valid |-> o_limit_status <= MAX_STATUS, "bad limit status")
    `PIDAW_ASSERT(a_ready_when_drained, !o_out_valid |-> o_in_ready, "input stalled while empty")
    `PIDAW_ASSERT(a_result_holds, p_result_holds, "stalled result changed")
    `PIDAW_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind pid_controller_anti_windup pidaw_assert #(.DATA_WIDTH(DATA_WIDTH)) u_pidaw_assert (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// PID controller with anti-windup testbench
// Drives setpoint/measurement items through the valid/ready input and programs
// gains, limits and modes over APB. Predicts every control output and limit
// status with a local fixed-point model of the loop, and checks each result in
// order. Directed corners come first, then randomized settings and items under
// varying source and sink idling, including one long output stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int DW     = pidaw_pkg::DATA_WIDTH_DEF;
    localparam int ADDR_W = pidaw_pkg::apb_lsb(DW) + pidaw_pkg::REG_INDEX_W;
    localparam int PD_W   = pidaw_pkg::apb_data_w(DW);

    class t_pid_loop_tracker;
        longint kp, ki, kd, out_lo, out_hi;
        bit aw_enable, compute_en;
        longint integral, prev_err, held;
        logic signed [DW-1:0] drive_q[$];
        pidaw_pkg::t_limit_status status_q[$];
        int errors;

        function new();
            kp = longint'(1) << pidaw_pkg::FRAC_BITS_DEF;
            ki = 0;
            kd = 0;
            out_lo = -(longint'(1) << (DW - 1));
            out_hi = (longint'(1) << (DW - 1)) - 1;
            aw_enable = 1'b1;
            compute_en = 1'b1;
            integral = 0;
            prev_err = 0;
            held = 0;
            errors = 0;
        endfunction

        function void write_reg(pidaw_pkg::t_reg_index idx, logic [DW-1:0] value);
            case (idx)
                pidaw_pkg::REG_KP:          kp = $signed(value);
                pidaw_pkg::REG_KI:          ki = $signed(value);
                pidaw_pkg::REG_KD:          kd = $signed(value);
                pidaw_pkg::REG_OUT_LOW:     out_lo = $signed(value);
                pidaw_pkg::REG_OUT_HIGH:    out_hi = $signed(value);
                pidaw_pkg::REG_ANTI_WINDUP: aw_enable = value[0];
                pidaw_pkg::REG_AUTO_MODE:   compute_en = value[0];
                default: ;
            endcase
        endfunction

        // floor of gain * x / 2^FRAC, capped at +-2^60
        function longint scaled_product(longint gain, longint x);
            logic signed [127:0] a, b, prod, cap;
            a = gain;
            b = x;
            cap = 128'sd1 <<< pidaw_pkg::TERM_LIMIT_LOG2;
            prod = (a * b) >>> pidaw_pkg::FRAC_BITS_DEF;
            if (prod > cap) prod = cap;
            else if (prod < -cap) prod = -cap;
            return prod[63:0];
        endfunction

        function void take_sample(logic mode, logic signed [DW-1:0] target,
                                  logic signed [DW-1:0] measured);
            longint err, p, ni, d, u, top;
            bit store;
            pidaw_pkg::t_limit_status status;
            status = pidaw_pkg::LIMIT_NONE;
            top = (longint'(1) << (pidaw_pkg::INTEG_W - 1)) - 1;
            if (mode == pidaw_pkg::MODE_CLEAR) begin
                integral = 0;
                prev_err = 0;
                held = 0;
            end else if (compute_en) begin
                err = longint'(target) - longint'(measured);
                p = scaled_product(kp, err);
                ni = integral + scaled_product(ki, err);
                if (ni > top) ni = top;
                else if (ni < -top - 1) ni = -top - 1;
                d = scaled_product(kd, err - prev_err);
                u = p + ni + d;
                store = 1'b1;
                if (u > out_hi) begin
                    u = out_hi;
                    status = pidaw_pkg::LIMIT_HIGH;
                    store = !aw_enable || err <= 0;
                end else if (u < out_lo) begin
                    u = out_lo;
                    status = pidaw_pkg::LIMIT_LOW;
                    store = !aw_enable || err >= 0;
                end
                if (store) integral = ni;
                prev_err = err;
                held = u;
            end
            drive_q.push_back(held[DW-1:0]);
            status_q.push_back(status);
        endfunction

        function void check_drive(logic signed [DW-1:0] drive, logic [1:0] stat);
            logic signed [DW-1:0] want_drive;
            pidaw_pkg::t_limit_status want_status;
            if (drive_q.size() == 0) begin
                $error("result with no item pending: control_output %0d", drive);
                errors++;
                return;
            end
            want_drive = drive_q.pop_front();
            want_status = status_q.pop_front();
            if (drive !== want_drive) begin
                $error("control_output: expected %0d, actual %0d", want_drive, drive);
                errors++;
            end
            if (stat !== want_status) begin
                $error("limit_status: expected %0d, actual %0d", want_status, stat);
                errors++;
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [PD_W-1:0]      pwdata = '0;
    logic [PD_W-1:0]      prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_mode = pidaw_pkg::MODE_UPDATE;
    logic signed [DW-1:0] i_target_value = '0;
    logic signed [DW-1:0] i_measured_value = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [DW-1:0] o_control_output;
    logic [1:0]           o_limit_status;

    t_pid_loop_tracker loop_model = new();
    int tx_idle_pct = 11;
    int rx_idle_pct = 82;
    bit rx_hold_req = 1'b0;
    int rx_hold_left = 0;

    pid_controller_anti_windup u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_target_value   (i_target_value),
        .i_measured_value (i_measured_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_control_output (o_control_output),
        .o_limit_status   (o_limit_status)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            loop_model.check_drive(o_control_output, o_limit_status);
        if (rx_hold_req) begin
            rx_hold_left = 60;
            rx_hold_req = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic mode, input logic [DW-1:0] target,
                             input logic [DW-1:0] measured);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_target_value <= target;
        i_measured_value <= measured;
        do @(posedge i_clk); while (!o_in_ready);
        loop_model.take_sample(mode, target, measured);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (loop_model.pending() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input pidaw_pkg::t_reg_index idx, input logic [DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << pidaw_pkg::apb_lsb(DW);
        pwdata <= PD_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        loop_model.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic pick_settings();
        logic [DW-1:0] lo, hi, kp;
        case ($urandom_range(9))
            0: kp = 32'h7fff_ffff;
            1: kp = 32'h8000_0000;
            2: kp = '0;
            default: kp = $urandom_range(32'h80000) - 32'h40000;
        endcase
        case ($urandom_range(3))
            0: begin
                lo = 32'h8000_0000;
                hi = 32'h7fff_ffff;
            end
            1: begin
                hi = $urandom_range(32'hC8_0000) + 32'h1_0000;
                lo = '0 - hi;
            end
            2: begin
                lo = $urandom_range(32'h10_0000);
                hi = lo - $urandom_range(32'h10_0000) - 1;
            end
            default: begin
                lo = $urandom();
                hi = $urandom();
            end
        endcase
        reg_write(pidaw_pkg::REG_KP, kp);
        reg_write(pidaw_pkg::REG_KI, ($urandom_range(9) == 0) ? $urandom()
                  : $urandom_range(32'h8000) - 32'h4000);
        reg_write(pidaw_pkg::REG_KD, ($urandom_range(9) == 0) ? $urandom()
                  : $urandom_range(32'h2_0000) - 32'h1_0000);
        reg_write(pidaw_pkg::REG_OUT_LOW, lo);
        reg_write(pidaw_pkg::REG_OUT_HIGH, hi);
        reg_write(pidaw_pkg::REG_ANTI_WINDUP, $urandom_range(1));
        reg_write(pidaw_pkg::REG_AUTO_MODE, DW'($urandom_range(7) != 0));
    endtask

    task automatic random_item();
        logic [DW-1:0] target, measured;
        int r;
        r = $urandom_range(99);
        if (r < 5) begin
            send_item(pidaw_pkg::MODE_CLEAR, $urandom(), $urandom());
        end else if (r < 25) begin
            send_item(pidaw_pkg::MODE_UPDATE, $urandom(), $urandom());
        end else begin
            target = $urandom_range(32'h80_0000) - 32'h40_0000;
            measured = target - ($urandom_range(32'h10_0000) - 32'h8_0000);
            send_item(pidaw_pkg::MODE_UPDATE, target, measured);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unity Kp, full-range limits
        send_item(pidaw_pkg::MODE_UPDATE, 32'h0, 32'h0);
        send_item(pidaw_pkg::MODE_UPDATE, 32'h7fff_ffff, 32'h8000_0000);
        send_item(pidaw_pkg::MODE_UPDATE, 32'h8000_0000, 32'h7fff_ffff);
        send_item(pidaw_pkg::MODE_UPDATE, 32'h1, 32'h0);
        send_item(pidaw_pkg::MODE_UPDATE, 32'hffff_ffff, 32'h0);
        send_item(pidaw_pkg::MODE_CLEAR, 32'hffff_ffff, 32'hffff_ffff);

        // narrow limits, anti-windup on
        settle();
        reg_write(pidaw_pkg::REG_KP, 32'h0002_0000);
        reg_write(pidaw_pkg::REG_KI, 32'h0000_8000);
        reg_write(pidaw_pkg::REG_KD, 32'h0001_0000);
        reg_write(pidaw_pkg::REG_OUT_LOW, 32'hfff6_0000);
        reg_write(pidaw_pkg::REG_OUT_HIGH, 32'h000a_0000);
        reg_write(pidaw_pkg::REG_ANTI_WINDUP, 32'h1);
        reg_write(pidaw_pkg::REG_AUTO_MODE, 32'h1);
        send_item(pidaw_pkg::MODE_UPDATE, 32'h0003_0000, 32'h0001_0000);
        send_item(pidaw_pkg::MODE_UPDATE, 32'h0064_0000, 32'h0);
        send_item(pidaw_pkg::MODE_UPDATE, 32'h0, 32'h0064_0000);

        // manual mode holds the output; clear still applies
        settle();
        reg_write(pidaw_pkg::REG_AUTO_MODE, 32'h0);
        send_item(pidaw_pkg::MODE_UPDATE, 32'h0005_0000, 32'h0);
        send_item(pidaw_pkg::MODE_CLEAR, 32'h0, 32'h0);
        send_item(pidaw_pkg::MODE_UPDATE, 32'h0005_0000, 32'h0);

        // crossed limits
        settle();
        reg_write(pidaw_pkg::REG_AUTO_MODE, 32'h1);
        reg_write(pidaw_pkg::REG_OUT_LOW, 32'h0005_0000);
        reg_write(pidaw_pkg::REG_OUT_HIGH, 32'hfffb_0000);
        send_item(pidaw_pkg::MODE_UPDATE, 32'h0, 32'h0);
        send_item(pidaw_pkg::MODE_UPDATE, 32'h0, 32'h0064_0000);

        // extreme gains, integral saturation, anti-windup off
        settle();
        reg_write(pidaw_pkg::REG_KP, 32'h8000_0000);
        reg_write(pidaw_pkg::REG_KI, 32'h7fff_ffff);
        reg_write(pidaw_pkg::REG_KD, 32'h7fff_ffff);
        reg_write(pidaw_pkg::REG_OUT_LOW, 32'h8000_0000);
        reg_write(pidaw_pkg::REG_OUT_HIGH, 32'h7fff_ffff);
        reg_write(pidaw_pkg::REG_ANTI_WINDUP, 32'h0);
        repeat (3) send_item(pidaw_pkg::MODE_UPDATE, 32'h7fff_ffff, 32'h8000_0000);
        repeat (3) send_item(pidaw_pkg::MODE_UPDATE, 32'h8000_0000, 32'h7fff_ffff);

        for (int chunk = 0; chunk < 6; chunk++) begin
            settle();
            tx_idle_pct = (chunk < 2) ? 11 : (chunk < 4) ? 82 : 0;
            rx_idle_pct = (chunk < 2) ? 82 : (chunk < 4) ? 11 : 0;
            pick_settings();
            for (int n = 0; n < 175; n++) begin
                if (chunk == 4 && n == 60) rx_hold_req = 1'b1;
                random_item();
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (loop_model.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pidaw_pkg.sv
rtl/pidaw_mul_term.sv
rtl/pid_controller_anti_windup.sv
rtl/pidaw_assert.sv
tb/sv/tb.sv
